>>> rtl/bba_pkg.sv
// bba_pkg: constants, types and helpers shared by the buddy allocator files.
// Depends on nothing; bba_seq and the top level in rtl/ refer to it by scoped names.

package bba_pkg;

   // Pool geometry
   localparam int MaxOrder    = 10;
   localparam int HeaderBytes = 40;
   localparam int MinBlock    = 40;

   localparam int SlotW   = MaxOrder;                  // basic-block offset
   localparam int OrdW    = $clog2(MaxOrder + 2);      // order, also holds MaxOrder+1
   localparam int NodeW   = MaxOrder + 1;              // heap index of a tree node
   localparam int RowW    = 5;                         // bit position inside a map row
   localparam int RowBits = 1 << RowW;
   localparam int RowCnt  = (1 << NodeW) / RowBits;
   localparam int RowAw   = NodeW - RowW;
   localparam int CntW    = MaxOrder + 1;              // free-node count per order
   localparam int GmW     = OrdW + 1;                  // grant mark and order
   localparam int BsW     = 16;
   localparam int ReqW    = 24;
   localparam int LenW    = ReqW + 1;
   localparam int BshW    = BsW + MaxOrder + 1;

   // Register indexes
   localparam logic [1:0] CSR_BLOCK_SIZE = 2'd0;
   localparam logic [1:0] CSR_POOL_ORDER = 2'd1;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_TOO_LARGE = 2'd1,
      ST_NO_BLOCK  = 2'd2,
      ST_BAD_FREE  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_SIZE,
      S_FIND,
      S_ROW_SEL,
      S_ROW_PICK,
      S_SET_RD,
      S_SET_WR,
      S_GRANT_WR,
      S_GRD_RD,
      S_GRD_CHK,
      S_MRG_TEST,
      S_BUD_CHK,
      S_DONE
   } state_type;

   // Effective configuration handed to the sequencer
   typedef struct packed {
      logic [BsW-1:0]  block_size;   // already raised to the minimum
      logic [OrdW-1:0] pool;         // already limited to MaxOrder
      logic            init;         // pool reinitialisation request
   } cfg_type;

   // Free-map memory port
   typedef struct packed {
      logic               we;
      logic [RowAw-1:0]   waddr;
      logic [RowBits-1:0] wdata;
      logic [RowAw-1:0]   raddr;
   } fm_port_type;

   // Grant memory port
   typedef struct packed {
      logic             we;
      logic [SlotW-1:0] waddr;
      logic [GmW-1:0]   wdata;
      logic [SlotW-1:0] raddr;
   } gm_port_type;

   // Heap index of the node of order k at offset off: 2^(MaxOrder-k) + off/2^k
   function automatic logic [NodeW-1:0] heap_idx(input logic [OrdW-1:0] k,
                                                 input logic [SlotW-1:0] off);
      heap_idx = (NodeW'(1) << (OrdW'(MaxOrder) - k)) + NodeW'(off >> k);
   endfunction

endpackage

>>> rtl/bba_ram.sv
// bba_ram: generic single-clock RAM, one write and one read port, registered read.
// Depends on nothing.

module bba_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   // Write port and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/bba_seq.sv
// bba_seq: request sequencer of the buddy allocator; walks the free map and grant
// memory one row access at a time. Depends on bba_pkg.

module bba_seq (
   input  logic                         clock,
   input  logic                         reset,
   input  bba_pkg::cfg_type             cfg,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_kind,
   input  logic [bba_pkg::ReqW-1:0]     req_request_bytes,
   input  logic [bba_pkg::SlotW-1:0]    req_free_offset,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_status,
   output logic [bba_pkg::SlotW-1:0]    rsp_block_offset,
   output logic [bba_pkg::OrdW-1:0]     rsp_block_order,
   output bba_pkg::fm_port_type         fm,
   input  logic [bba_pkg::RowBits-1:0]  fm_rdata,
   output bba_pkg::gm_port_type         gm,
   input  logic [bba_pkg::GmW-1:0]      gm_rdata
);

   bba_pkg::state_type state_ff, state_in;

   logic [bba_pkg::LenW-1:0]  len_ff, len_in;
   logic [bba_pkg::BshW-1:0]  bsh_ff, bsh_in;
   logic [bba_pkg::OrdW-1:0]  o_ff, o_in;
   logic [bba_pkg::OrdW-1:0]  k_ff, k_in;
   logic [bba_pkg::OrdW-1:0]  go_ff, go_in;
   logic [bba_pkg::SlotW-1:0] off_ff, off_in;
   logic [bba_pkg::SlotW-1:0] req_off_ff, req_off_in;
   logic [bba_pkg::NodeW-1:0] h_ff, h_in;
   logic [bba_pkg::RowAw-1:0] row_ff, row_in;
   logic                      split_ff, split_in;
   logic [bba_pkg::SlotW-1:0] clr_ff, clr_in;

   bba_pkg::status_type       res_st_ff, res_st_in;
   logic [bba_pkg::SlotW-1:0] res_off_ff, res_off_in;
   logic [bba_pkg::OrdW-1:0]  res_ord_ff, res_ord_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   bba_pkg::status_type       rsp_st_ff, rsp_st_in;
   logic [bba_pkg::SlotW-1:0] rsp_off_ff, rsp_off_in;
   logic [bba_pkg::OrdW-1:0]  rsp_ord_ff, rsp_ord_in;

   logic [bba_pkg::CntW-1:0]  cnt_ff [bba_pkg::MaxOrder+1];
   logic [bba_pkg::CntW-1:0]  cnt_in [bba_pkg::MaxOrder+1];
   logic [bba_pkg::RowCnt-1:0] row_nz_ff, row_nz_in;

   // Search and address helpers
   logic                        find_ok;
   logic [bba_pkg::OrdW-1:0]    find_k;
   logic [bba_pkg::NodeW-1:0]   lo_h;
   logic [bba_pkg::NodeW:0]     hi_h;
   logic [bba_pkg::RowAw-1:0]   lo_row, hi_row, first_row;
   logic [bba_pkg::RowW-1:0]    pick_b;
   logic [bba_pkg::NodeW-1:0]   pick_h, hb;
   logic [bba_pkg::SlotW-1:0]   pick_off;
   logic [bba_pkg::NodeW-1:0]   split_h_pick, split_h_set, bud_h, own_h, root_h;
   logic                        bud_free, grd_bad, clr_last;
   logic [bba_pkg::RowBits-1:0] h_mask;

   // Lowest order at or above the fitting order that still has a free node
   always_comb begin
      find_ok = 1'b0;
      find_k  = '0;
      for (int i = bba_pkg::MaxOrder; i >= 0; i--) begin
         if (bba_pkg::OrdW'(i) >= o_ff && bba_pkg::OrdW'(i) <= cfg.pool
             && cnt_ff[i] != '0) begin
            find_ok = 1'b1;
            find_k  = bba_pkg::OrdW'(i);
         end
      end
   end

   // Rows holding order k_ff and the first of them with a free node
   always_comb begin
      lo_h      = bba_pkg::NodeW'(1) << (bba_pkg::OrdW'(bba_pkg::MaxOrder) - k_ff);
      hi_h      = ({1'b0, lo_h} << 1) - (bba_pkg::NodeW+1)'(1);
      lo_row    = lo_h[bba_pkg::NodeW-1:bba_pkg::RowW];
      hi_row    = hi_h[bba_pkg::NodeW-1:bba_pkg::RowW];
      first_row = lo_row;
      for (int r = bba_pkg::RowCnt - 1; r >= 0; r--) begin
         if (row_nz_ff[r] && bba_pkg::RowAw'(r) >= lo_row
             && bba_pkg::RowAw'(r) <= hi_row) begin
            first_row = bba_pkg::RowAw'(r);
         end
      end
   end

   // Lowest free node of order k_ff inside the row just read
   always_comb begin
      pick_b = '0;
      hb     = '0;
      for (int b = bba_pkg::RowBits - 1; b >= 0; b--) begin
         hb = {row_ff, bba_pkg::RowW'(b)};
         if (fm_rdata[b] && hb >= lo_h && {1'b0, hb} <= hi_h) begin
            pick_b = bba_pkg::RowW'(b);
         end
      end
      pick_h       = {row_ff, pick_b};
      pick_off     = bba_pkg::SlotW'((pick_h - lo_h) << k_ff);
      split_h_pick = bba_pkg::heap_idx(k_ff - bba_pkg::OrdW'(1),
                        pick_off | (bba_pkg::SlotW'(1) << (k_ff - bba_pkg::OrdW'(1))));
      split_h_set  = bba_pkg::heap_idx(k_ff - bba_pkg::OrdW'(1),
                        off_ff | (bba_pkg::SlotW'(1) << (k_ff - bba_pkg::OrdW'(1))));
      bud_h        = bba_pkg::heap_idx(k_ff, off_ff ^ (bba_pkg::SlotW'(1) << k_ff));
      own_h        = bba_pkg::heap_idx(k_ff, off_ff);
      root_h       = bba_pkg::NodeW'(1) << (bba_pkg::OrdW'(bba_pkg::MaxOrder) - cfg.pool);
      h_mask       = bba_pkg::RowBits'(1) << h_ff[bba_pkg::RowW-1:0];
      bud_free     = fm_rdata[h_ff[bba_pkg::RowW-1:0]];
      grd_bad      = !gm_rdata[bba_pkg::OrdW] || gm_rdata[bba_pkg::OrdW-1:0] > cfg.pool;
      clr_last     = (clr_ff == {bba_pkg::SlotW{1'b1}});
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bba_pkg::S_CLEAR: begin
            if (clr_last) state_in = bba_pkg::S_IDLE;
         end
         bba_pkg::S_IDLE: begin
            if (req_valid) begin
               if (!req_kind) begin
                  state_in = bba_pkg::S_SIZE;
               end else if (({1'b0, req_free_offset} >> cfg.pool) != '0) begin
                  state_in = bba_pkg::S_DONE;
               end else begin
                  state_in = bba_pkg::S_GRD_RD;
               end
            end
         end
         bba_pkg::S_SIZE: begin
            if (o_ff > cfg.pool) begin
               state_in = bba_pkg::S_DONE;
            end else if (bsh_ff >= bba_pkg::BshW'(len_ff)) begin
               state_in = bba_pkg::S_FIND;
            end
         end
         bba_pkg::S_FIND:     state_in = find_ok ? bba_pkg::S_ROW_SEL : bba_pkg::S_DONE;
         bba_pkg::S_ROW_SEL:  state_in = bba_pkg::S_ROW_PICK;
         bba_pkg::S_ROW_PICK: begin
            state_in = (k_ff > o_ff) ? bba_pkg::S_SET_RD : bba_pkg::S_GRANT_WR;
         end
         bba_pkg::S_SET_RD:   state_in = bba_pkg::S_SET_WR;
         bba_pkg::S_SET_WR: begin
            if (!split_ff) begin
               state_in = bba_pkg::S_DONE;
            end else if (k_ff > o_ff) begin
               state_in = bba_pkg::S_SET_RD;
            end else begin
               state_in = bba_pkg::S_GRANT_WR;
            end
         end
         bba_pkg::S_GRANT_WR: state_in = bba_pkg::S_DONE;
         bba_pkg::S_GRD_RD:   state_in = bba_pkg::S_GRD_CHK;
         bba_pkg::S_GRD_CHK:  state_in = grd_bad ? bba_pkg::S_DONE : bba_pkg::S_MRG_TEST;
         bba_pkg::S_MRG_TEST: begin
            state_in = (k_ff < cfg.pool) ? bba_pkg::S_BUD_CHK : bba_pkg::S_SET_RD;
         end
         bba_pkg::S_BUD_CHK:  state_in = bud_free ? bba_pkg::S_MRG_TEST : bba_pkg::S_SET_RD;
         bba_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = bba_pkg::S_IDLE;
         end
         default:             state_in = bba_pkg::S_CLEAR;
      endcase
      if (cfg.init) state_in = bba_pkg::S_CLEAR;
   end

   // Memory ports and request handshake
   always_comb begin
      fm        = '0;
      gm        = '0;
      req_ready = (state_ff == bba_pkg::S_IDLE);
      case (state_ff)
         bba_pkg::S_CLEAR: begin
            gm.we    = 1'b1;
            gm.waddr = clr_ff;
            gm.wdata = '0;
            fm.we    = (clr_ff >> bba_pkg::RowAw) == '0;
            fm.waddr = clr_ff[bba_pkg::RowAw-1:0];
            fm.wdata = (clr_ff[bba_pkg::RowAw-1:0] == root_h[bba_pkg::NodeW-1:bba_pkg::RowW])
                       ? (bba_pkg::RowBits'(1) << root_h[bba_pkg::RowW-1:0]) : '0;
         end
         bba_pkg::S_ROW_SEL: fm.raddr = first_row;
         bba_pkg::S_ROW_PICK: begin
            fm.we    = 1'b1;
            fm.waddr = row_ff;
            fm.wdata = fm_rdata & ~(bba_pkg::RowBits'(1) << pick_b);
         end
         bba_pkg::S_SET_RD: fm.raddr = h_ff[bba_pkg::NodeW-1:bba_pkg::RowW];
         bba_pkg::S_SET_WR: begin
            fm.we    = 1'b1;
            fm.waddr = h_ff[bba_pkg::NodeW-1:bba_pkg::RowW];
            fm.wdata = fm_rdata | h_mask;
         end
         bba_pkg::S_GRANT_WR: begin
            gm.we    = 1'b1;
            gm.waddr = off_ff;
            gm.wdata = {1'b1, o_ff};
         end
         bba_pkg::S_GRD_RD: gm.raddr = req_off_ff;
         bba_pkg::S_GRD_CHK: begin
            gm.we    = !grd_bad;
            gm.waddr = req_off_ff;
            gm.wdata = {1'b0, gm_rdata[bba_pkg::OrdW-1:0]};
         end
         bba_pkg::S_MRG_TEST: fm.raddr = bud_h[bba_pkg::NodeW-1:bba_pkg::RowW];
         bba_pkg::S_BUD_CHK: begin
            fm.we    = bud_free;
            fm.waddr = h_ff[bba_pkg::NodeW-1:bba_pkg::RowW];
            fm.wdata = fm_rdata & ~h_mask;
         end
         default: ;
      endcase
   end

   // Datapath next values
   always_comb begin
      len_in     = len_ff;
      bsh_in     = bsh_ff;
      o_in       = o_ff;
      k_in       = k_ff;
      go_in      = go_ff;
      off_in     = off_ff;
      req_off_in = req_off_ff;
      h_in       = h_ff;
      row_in     = row_ff;
      split_in   = split_ff;
      clr_in     = clr_ff;
      res_st_in  = res_st_ff;
      res_off_in = res_off_ff;
      res_ord_in = res_ord_ff;
      cnt_in     = cnt_ff;
      row_nz_in  = row_nz_ff;

      // Row summary follows every map write outside the clearing pass
      if (fm.we && state_ff != bba_pkg::S_CLEAR) begin
         row_nz_in[fm.waddr] = |fm.wdata;
      end

      case (state_ff)
         bba_pkg::S_CLEAR: begin
            clr_in = clr_ff + bba_pkg::SlotW'(1);
            if (clr_ff == '0) begin
               for (int i = 0; i <= bba_pkg::MaxOrder; i++) begin
                  cnt_in[i] = (bba_pkg::OrdW'(i) == cfg.pool) ? bba_pkg::CntW'(1) : '0;
               end
               for (int r = 0; r < bba_pkg::RowCnt; r++) begin
                  row_nz_in[r] = (bba_pkg::RowAw'(r) ==
                                  root_h[bba_pkg::NodeW-1:bba_pkg::RowW]);
               end
            end
         end
         bba_pkg::S_IDLE: begin
            len_in     = bba_pkg::LenW'(req_request_bytes) + bba_pkg::LenW'(bba_pkg::HeaderBytes);
            bsh_in     = bba_pkg::BshW'(cfg.block_size);
            o_in       = '0;
            req_off_in = req_free_offset;
            res_st_in  = bba_pkg::ST_BAD_FREE;
            res_off_in = req_free_offset;
            res_ord_in = '0;
         end
         bba_pkg::S_SIZE: begin
            if (o_ff > cfg.pool) begin
               res_st_in  = bba_pkg::ST_TOO_LARGE;
               res_off_in = '0;
            end else if (bsh_ff < bba_pkg::BshW'(len_ff)) begin
               o_in   = o_ff + bba_pkg::OrdW'(1);
               bsh_in = bsh_ff << 1;
            end
         end
         bba_pkg::S_FIND: begin
            k_in       = find_k;
            res_st_in  = bba_pkg::ST_NO_BLOCK;
            res_off_in = '0;
         end
         bba_pkg::S_ROW_SEL: row_in = first_row;
         bba_pkg::S_ROW_PICK: begin
            cnt_in[k_ff] = cnt_ff[k_ff] - bba_pkg::CntW'(1);
            off_in       = pick_off;
            split_in     = 1'b1;
            if (k_ff > o_ff) begin
               k_in = k_ff - bba_pkg::OrdW'(1);
               h_in = split_h_pick;
            end
         end
         bba_pkg::S_SET_WR: begin
            cnt_in[k_ff] = cnt_ff[k_ff] + bba_pkg::CntW'(1);
            if (!split_ff) begin
               res_st_in  = bba_pkg::ST_OK;
               res_off_in = req_off_ff;
               res_ord_in = go_ff;
            end else if (k_ff > o_ff) begin
               k_in = k_ff - bba_pkg::OrdW'(1);
               h_in = split_h_set;
            end
         end
         bba_pkg::S_GRANT_WR: begin
            res_st_in  = bba_pkg::ST_OK;
            res_off_in = off_ff;
            res_ord_in = o_ff;
         end
         bba_pkg::S_GRD_CHK: begin
            k_in     = gm_rdata[bba_pkg::OrdW-1:0];
            go_in    = gm_rdata[bba_pkg::OrdW-1:0];
            off_in   = req_off_ff;
            split_in = 1'b0;
         end
         bba_pkg::S_MRG_TEST: begin
            h_in = (k_ff < cfg.pool) ? bud_h : own_h;
         end
         bba_pkg::S_BUD_CHK: begin
            if (bud_free) begin
               cnt_in[k_ff] = cnt_ff[k_ff] - bba_pkg::CntW'(1);
               off_in       = off_ff & ~(bba_pkg::SlotW'(1) << k_ff);
               k_in         = k_ff + bba_pkg::OrdW'(1);
            end else begin
               h_in = own_h;
            end
         end
         default: ;
      endcase
      if (cfg.init) clr_in = '0;
   end

   // Result register: takes a new result as soon as the previous one has gone
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_off_in   = rsp_off_ff;
      rsp_ord_in   = rsp_ord_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (state_ff == bba_pkg::S_DONE && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_in = 1'b1;
         rsp_st_in    = res_st_ff;
         rsp_off_in   = res_off_ff;
         rsp_ord_in   = res_ord_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bba_pkg::S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         split_ff     <= 1'b0;
         row_nz_ff    <= '0;
         for (int i = 0; i <= bba_pkg::MaxOrder; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         split_ff     <= split_in;
         row_nz_ff    <= row_nz_in;
         cnt_ff       <= cnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      len_ff     <= len_in;
      bsh_ff     <= bsh_in;
      o_ff       <= o_in;
      k_ff       <= k_in;
      go_ff      <= go_in;
      off_ff     <= off_in;
      req_off_ff <= req_off_in;
      h_ff       <= h_in;
      row_ff     <= row_in;
      res_st_ff  <= res_st_in;
      res_off_ff <= res_off_in;
      res_ord_ff <= res_ord_in;
      rsp_st_ff  <= rsp_st_in;
      rsp_off_ff <= rsp_off_in;
      rsp_ord_ff <= rsp_ord_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_st_ff;
   assign rsp_block_offset = rsp_off_ff;
   assign rsp_block_order  = rsp_ord_ff;

endmodule

>>> rtl/buddy_block_allocator.sv
// Binary buddy allocator over a pool of 2^pool_order basic blocks. An allocate request
// finds the smallest fitting order o, one order per cycle, picks the lowest-addressed
// free block of the smallest order at or above o that has one, splits it down one level
// at a time, then writes the grant. A free request merges the block with its buddy
// level by level until a busy buddy or the pool order ends the merging; a refused
// free (outside the pool or not granted) ends early. Between requests the block returns
// to idle, and a result waits while the previous one is still held. Every node update
// in the free map is a read and a write-back of one 32-node row of that memory.
// After reset and after every pool_order write the block runs a clearing pass over
// the grant memory and the free map, during which no request is taken. Results wait
// in an output register, so a new request can be taken while the previous result is
// still held.
// Top level; depends on bba_pkg, bba_ram and bba_seq.

module buddy_block_allocator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_kind,
   input  logic [bba_pkg::ReqW-1:0]    req_request_bytes,
   input  logic [bba_pkg::SlotW-1:0]   req_free_offset,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_status,
   output logic [bba_pkg::SlotW-1:0]   rsp_block_offset,
   output logic [bba_pkg::OrdW-1:0]    rsp_block_order,
   input  logic                        csr_we,
   input  logic [1:0]                  csr_index,
   input  logic [bba_pkg::BsW-1:0]     csr_wdata
);

   logic [bba_pkg::BsW-1:0]     block_size_ff, block_size_in;
   logic [3:0]                  pool_order_ff, pool_order_in;
   bba_pkg::cfg_type            cfg;
   bba_pkg::fm_port_type        fm;
   bba_pkg::gm_port_type        gm;
   logic [bba_pkg::RowBits-1:0] fm_rdata;
   logic [bba_pkg::GmW-1:0]     gm_rdata;

   // Configuration registers
   always_comb begin
      block_size_in = block_size_ff;
      pool_order_in = pool_order_ff;
      if (csr_we && csr_index == bba_pkg::CSR_BLOCK_SIZE) block_size_in = csr_wdata;
      if (csr_we && csr_index == bba_pkg::CSR_POOL_ORDER) pool_order_in = csr_wdata[3:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff <= bba_pkg::BsW'(bba_pkg::MinBlock);
         pool_order_ff <= 4'(bba_pkg::MaxOrder);
      end else begin
         block_size_ff <= block_size_in;
         pool_order_ff <= pool_order_in;
      end
   end

   // Effective settings: block size no smaller than the header, pool no larger than the tree
   always_comb begin
      cfg.block_size = (block_size_ff < bba_pkg::BsW'(bba_pkg::MinBlock))
                       ? bba_pkg::BsW'(bba_pkg::MinBlock) : block_size_ff;
      cfg.pool       = (pool_order_ff > 4'(bba_pkg::MaxOrder))
                       ? bba_pkg::OrdW'(bba_pkg::MaxOrder) : bba_pkg::OrdW'(pool_order_ff);
      cfg.init       = csr_we && csr_index == bba_pkg::CSR_POOL_ORDER;
   end

   // Free map: one bit per tree node, 32 nodes a row
   bba_ram #(
      .Width (bba_pkg::RowBits),
      .Depth (bba_pkg::RowCnt)
   ) u_free_map (
      .clock (clock),
      .we    (fm.we),
      .waddr (fm.waddr),
      .wdata (fm.wdata),
      .raddr (fm.raddr),
      .rdata (fm_rdata)
   );

   // Grant memory: mark and order per basic-block offset
   bba_ram #(
      .Width (bba_pkg::GmW),
      .Depth (1 << bba_pkg::SlotW)
   ) u_grant_mem (
      .clock (clock),
      .we    (gm.we),
      .waddr (gm.waddr),
      .wdata (gm.wdata),
      .raddr (gm.raddr),
      .rdata (gm_rdata)
   );

   bba_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_request_bytes (req_request_bytes),
      .req_free_offset   (req_free_offset),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_block_offset  (rsp_block_offset),
      .rsp_block_order   (rsp_block_order),
      .fm                (fm),
      .fm_rdata          (fm_rdata),
      .gm                (gm),
      .gm_rdata          (gm_rdata)
   );

`ifndef SYNTH
   // Clearing pass follows reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request taken during clearing pass after reset");

   // A pool write restarts the clearing pass
   a_pool_clears: assert property (@(posedge clock) disable iff (reset)
      csr_we && csr_index == bba_pkg::CSR_POOL_ORDER |=> !req_ready)
      else $error("request taken right after pool reinitialisation");

   // A successful result never names a block larger than the pool
   a_order_in_pool: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == bba_pkg::ST_OK |-> rsp_block_order <= cfg.pool)
      else $error("granted or freed block order exceeds pool order");
`endif

endmodule

>>> sim/tb.sv
// tb: self-checking bench for buddy_block_allocator (allocate and free requests).
// Depends on rtl/bba_pkg.sv and the allocator RTL; keeps its own buddy tree model.
`timescale 1ns / 1ps

module tb;

   localparam int POOL_SLOTS = 1 << bba_pkg::MaxOrder;
   localparam int NODE_CNT   = 2 * POOL_SLOTS;
   localparam bit KIND_ALLOC = 1'b0;
   localparam bit KIND_FREE  = 1'b1;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic        kind;
      logic [23:0] nbytes;
      logic [9:0]  offset;
   } request_type;

   typedef struct packed {
      bba_pkg::status_type status;
      logic [9:0]          offset;
      logic [3:0]          order;
   } grant_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_kind = 1'b0;
   logic [bba_pkg::ReqW-1:0] req_request_bytes = '0;
   logic [bba_pkg::SlotW-1:0] req_free_offset = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic [bba_pkg::SlotW-1:0] rsp_block_offset;
   logic [bba_pkg::OrdW-1:0] rsp_block_order;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = '0;
   logic [bba_pkg::BsW-1:0] csr_wdata = '0;

   buddy_block_allocator dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // allocator model state (heap-indexed: node 2^(10-o) + off>>o)
   bit         node_free [NODE_CNT];
   bit         held      [POOL_SLOTS];
   logic [3:0] held_ord  [POOL_SLOTS];
   int unsigned blk_bytes, pool_lvl;
   int unsigned live_q[$];          // offsets currently granted, for legal frees

   request_type pending_q[$];
   grant_type   expected_q[$];
   int       n_fail = 0;
   bit       req_took = 1'b0;       // set at the accepting edge, seen by the driver
   bit       long_hold = 1'b0;      // asks the receiver for one long stall
   int       hold_cycles = 0;

   function automatic int node_at(int o, int off);
      return (1 << (bba_pkg::MaxOrder - o)) + (off >> o);
   endfunction

   function automatic void pool_clear();
      foreach (node_free[i]) node_free[i] = 0;
      foreach (held[i]) held[i] = 0;
      live_q.delete();
      node_free[node_at(pool_lvl, 0)] = 1;
   endfunction

   function automatic grant_type predict_grant(request_type r);
      grant_type g;
      longint need, bs;
      int o, k, off, bud;
      bit hit;
      g = '{bba_pkg::ST_OK, 10'd0, 4'd0};
      if (r.kind == KIND_ALLOC) begin
         need = longint'(r.nbytes) + bba_pkg::HeaderBytes;
         bs = blk_bytes < bba_pkg::MinBlock ? bba_pkg::MinBlock : blk_bytes;
         o = 0;
         while (o <= pool_lvl && (bs << o) < need) o++;
         if (o > pool_lvl) begin
            g.status = bba_pkg::ST_TOO_LARGE;
            return g;
         end
         hit = 0;
         for (k = o; k <= pool_lvl && !hit; k++)
            for (int a = 0; a < (1 << pool_lvl); a += (1 << k))
               if (node_free[node_at(k, a)]) begin
                  off = a; hit = 1; break;
               end
         if (!hit) begin
            g.status = bba_pkg::ST_NO_BLOCK;
            return g;
         end
         k--;
         node_free[node_at(k, off)] = 0;
         while (k > o) begin
            k--;
            node_free[node_at(k, off + (1 << k))] = 1;
         end
         held[off] = 1;
         held_ord[off] = o;
         live_q.push_back(off);
         g.offset = off;
         g.order = o;
      end else begin
         off = r.offset;
         g.offset = r.offset;
         if (off >= (1 << pool_lvl) || !held[off]) begin
            g.status = bba_pkg::ST_BAD_FREE;
            return g;
         end
         g.order = held_ord[off];
         held[off] = 0;
         foreach (live_q[i]) if (live_q[i] == off) begin
            live_q.delete(i); break;
         end
         o = held_ord[off];
         while (o < pool_lvl) begin
            bud = off ^ (1 << o);
            if (!node_free[node_at(o, bud)]) break;
            node_free[node_at(o, bud)] = 0;
            off &= ~(1 << o);
            o++;
         end
         node_free[node_at(o, off)] = 1;
      end
      return g;
   endfunction

   // request driver: bursts and gaps, fed from pending_q
   int gap_left = 0, burst_left = 0;
   always @(negedge clock) begin
      bit popped;
      popped = 1'b0;
      if (!reset) begin
         if (req_took) begin
            void'(pending_q.pop_front());
            burst_left--;
            req_took = 1'b0;
            popped = 1'b1;
         end
         if (gap_left > 0) gap_left--;
         if (burst_left <= 0 && gap_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
         end
         // an offered request that is still waiting stays as it is
         if (!(req_valid && !popped)) begin
            if (pending_q.size() > 0 && gap_left == 0) begin
               req_valid <= 1'b1;
               req_kind <= pending_q[0].kind;
               req_request_bytes <= pending_q[0].nbytes;
               req_free_offset <= pending_q[0].offset;
            end else
               req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls, plus one long hold counted here
   always @(negedge clock) begin
      if (!reset) begin
         if (long_hold) begin
            hold_cycles = 400;
            long_hold = 1'b0;
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ready <= 1'b0;
         end else
            rsp_ready <= ($urandom_range(0, 7) != 0);
      end
   end

   // prediction on acceptance, check on result
   always @(posedge clock) begin
      grant_type g;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_q.push_back(predict_grant('{req_kind, req_request_bytes,
                                                 req_free_offset}));
            req_took = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("result with no request outstanding");
               n_fail++;
            end else begin
               g = expected_q.pop_front();
               if (rsp_status !== g.status) begin
                  $error("status exp %0d got %0d", g.status, rsp_status); n_fail++;
               end
               if (rsp_block_offset !== g.offset) begin
                  $error("block_offset exp %0d got %0d", g.offset, rsp_block_offset);
                  n_fail++;
               end
               if (rsp_block_order !== bba_pkg::OrdW'(g.order)) begin
                  $error("block_order exp %0d got %0d", g.order, rsp_block_order);
                  n_fail++;
               end
            end
         end
      end
   end

   task automatic queue_req(bit kind, int unsigned nbytes, int unsigned off);
      request_type r;
      r.kind = kind; r.nbytes = nbytes; r.offset = off;
      pending_q.push_back(r);
   endtask

   // wait until drained and idle, then allow the block to settle
   task automatic drain();
      while (pending_q.size() > 0 || req_valid || expected_q.size() > 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, int unsigned val);
      @(negedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == bba_pkg::CSR_BLOCK_SIZE) blk_bytes = val & 16'hFFFF;
      else if (idx == bba_pkg::CSR_POOL_ORDER) begin
         pool_lvl = (val & 15) > bba_pkg::MaxOrder ? bba_pkg::MaxOrder : (val & 15);
         pool_clear();
      end
   endtask

   // a random phase: allocations, frees of random offsets and legal frees of live blocks
   task automatic random_phase(int count, int unsigned max_bytes);
      int unsigned b;
      for (int i = 0; i < count; i++) begin
         wait (pending_q.size() < 8);
         if ($urandom_range(0, 99) < 55) begin
            b = $urandom_range(0, 9) == 0 ? $urandom() & 24'hFFFFFF
                                           : $urandom_range(0, max_bytes);
            queue_req(KIND_ALLOC, b, 0);
         end else
            queue_req(KIND_FREE, 0, $urandom() & 10'h3FF);
         // let prediction catch up so frees target live blocks
         if ($urandom_range(0, 99) < 60) begin
            wait (pending_q.size() == 0);
            @(posedge clock); #0.1;
            if (live_q.size() > 0)
               queue_req(KIND_FREE, 0, live_q[$urandom_range(0, live_q.size() - 1)]);
         end
      end
      drain();
   endtask

   initial begin
      blk_bytes = 40; pool_lvl = bba_pkg::MaxOrder;
      pool_clear();
      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed: extremes, both kinds, every status
      queue_req(KIND_FREE, 0, 0);              // free of nothing granted
      queue_req(KIND_ALLOC, 0, 0);             // order 0
      queue_req(KIND_ALLOC, 1, 0);             // order 1
      queue_req(KIND_ALLOC, 24'hFFFFFF, 0);    // too large
      queue_req(KIND_ALLOC, 40000, 0);         // whole pool needed, not free
      queue_req(KIND_FREE, 0, 1);              // free block, not a granted start
      queue_req(KIND_FREE, 0, 0);
      queue_req(KIND_FREE, 0, 2);
      queue_req(KIND_ALLOC, 40920, 0);         // whole pool, order 10
      queue_req(KIND_ALLOC, 0, 0);             // no free block
      queue_req(KIND_FREE, 0, 10'h3FF);
      queue_req(KIND_FREE, 0, 0);
      drain();

      // long receiver hold so the block backs up
      long_hold = 1'b1;
      for (int i = 0; i < 12; i++) queue_req(KIND_ALLOC, $urandom_range(0, 200), 0);
      drain();

      csr_write(bba_pkg::CSR_POOL_ORDER, 0);
      csr_write(bba_pkg::CSR_BLOCK_SIZE, 0);   // below minimum acts as 40
      queue_req(KIND_ALLOC, 0, 0);
      queue_req(KIND_ALLOC, 1, 0);
      queue_req(KIND_FREE, 0, 0);
      queue_req(KIND_FREE, 0, 1);              // outside the pool
      queue_req(KIND_ALLOC, 1, 0);
      drain();
      csr_write(CSR_UNUSED, 123);              // unused index, ignored

      csr_write(bba_pkg::CSR_POOL_ORDER, 4);
      random_phase(110, 400);
      csr_write(bba_pkg::CSR_BLOCK_SIZE, 16'hFFFF);
      csr_write(bba_pkg::CSR_POOL_ORDER, 15);  // clamps to the maximum
      random_phase(110, 24'hFFFFFF);
      csr_write(bba_pkg::CSR_BLOCK_SIZE, 64);
      csr_write(bba_pkg::CSR_POOL_ORDER, 3);
      random_phase(110, 600);
      csr_write(bba_pkg::CSR_BLOCK_SIZE, 40);
      csr_write(bba_pkg::CSR_POOL_ORDER, 10);
      random_phase(150, 5000);
      csr_write(bba_pkg::CSR_POOL_ORDER, 1);
      random_phase(80, 100);

      if (n_fail == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #4000000;
      $display("TB_ERROR");
      $finish;
   end
endmodule
